// File: rtl/speck128_128_block_cipher_unit_assert.svh
// Assertion macros shared by the cipher unit.
`ifndef SPECK128_128_BLOCK_CIPHER_UNIT_ASSERT_SVH
`define SPECK128_128_BLOCK_CIPHER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPK_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("cipher unit assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SPK_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("cipher unit assertion failed");

`endif

// File: rtl/spk_pkg.sv
`timescale 1ns / 1ps
package spk_pkg;

	localparam int WORD_W          = 64;
	localparam int CFG_IDX_W       = 8;
	localparam int ROUND_COUNT_DEF = 32;
	localparam int ROT_X           = 8;
	localparam int ROT_Y           = 3;

	localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = CFG_IDX_W'(1);

	typedef logic [WORD_W-1:0] word_t;

	typedef struct packed {
		logic load_block;   // take a new block from the input transfer
		logic load_expand;  // seed the round registers with the key words
		logic step;         // advance the round registers by one round
		logic expand;       // current step belongs to key expansion
		logic wr_rk;        // store the current A word as a round key
		logic load_out;     // copy the finished block to the result register
	} dp_cmd_t;

	typedef struct packed {
		logic key_write;    // a key register is written this cycle
	} dp_status_t;

	typedef struct packed {
		word_t x;
		word_t y;
	} pair_t;

	function automatic word_t rotr(input word_t v, input int n);
		return (v >> n) | (v << (WORD_W - n));
	endfunction

	function automatic word_t rotl(input word_t v, input int n);
		return (v << n) | (v >> (WORD_W - n));
	endfunction

	function automatic pair_t fwd_round(input word_t x, input word_t y, input word_t k);
		pair_t r;
		r.x = (rotr(x, ROT_X) + y) ^ k;
		r.y = rotl(y, ROT_Y) ^ r.x;
		return r;
	endfunction

	function automatic pair_t inv_round(input word_t x, input word_t y, input word_t k);
		pair_t r;
		r.y = rotr(y ^ x, ROT_Y);
		r.x = rotl((x ^ k) - r.y, ROT_X);
		return r;
	endfunction

endpackage

// File: rtl/spk_in_if.sv
`timescale 1ns / 1ps
interface spk_in_if;
	logic                      valid;
	logic                      ready;
	logic                      kind;
	logic [spk_pkg::WORD_W-1:0] data_in_low;
	logic [spk_pkg::WORD_W-1:0] data_in_high;

	modport source (output valid, output kind, output data_in_low, output data_in_high,
		input ready);
	modport sink (input valid, input kind, input data_in_low, input data_in_high,
		output ready);
endinterface

// File: rtl/spk_out_if.sv
`timescale 1ns / 1ps
interface spk_out_if;
	logic                      valid;
	logic                      ready;
	logic [spk_pkg::WORD_W-1:0] data_out_low;
	logic [spk_pkg::WORD_W-1:0] data_out_high;

	modport source (output valid, output data_out_low, output data_out_high, input ready);
	modport sink (input valid, input data_out_low, input data_out_high, output ready);
endinterface

// File: rtl/spk_cfg_if.sv
`timescale 1ns / 1ps
interface spk_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [spk_pkg::CFG_IDX_W-1:0] index;
	logic [spk_pkg::WORD_W-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/spk_datapath.sv
`timescale 1ns / 1ps
module spk_datapath #(
	parameter int ROUND_COUNT = spk_pkg::ROUND_COUNT_DEF,
	parameter int RND_W       = $clog2(ROUND_COUNT)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  spk_pkg::dp_cmd_t              cmd,
	input  logic [RND_W-1:0]              round,
	output spk_pkg::dp_status_t           status,
	input  logic                          cfg_fire,
	input  logic [spk_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [spk_pkg::WORD_W-1:0]    cfg_data,
	input  logic                          kind,
	input  logic [spk_pkg::WORD_W-1:0]    data_in_low,
	input  logic [spk_pkg::WORD_W-1:0]    data_in_high,
	output logic [spk_pkg::WORD_W-1:0]    data_out_low,
	output logic [spk_pkg::WORD_W-1:0]    data_out_high
);
	import spk_pkg::*;

	localparam logic [RND_W-1:0] LAST_ROUND = RND_W'(ROUND_COUNT - 1);

	word_t key_low_q, key_high_q;
	word_t x_q, y_q;
	word_t out_low_q, out_high_q;
	logic  kind_q;
	word_t rk_mem [ROUND_COUNT];
	word_t rk_rd_q;

	logic [RND_W-1:0] rk_addr, round_nx;
	logic             dir_nx;
	word_t            round_key;
	pair_t            fwd_res, inv_res, next_pair;

	always_comb begin
		status.key_write = cfg_fire && (cfg_index == REG_KEY_LOW || cfg_index == REG_KEY_HIGH);
	end

	// The key for the next round is read into a register ahead of use, so the address follows the
	// round and direction that will be current after this edge.
	// Decryption walks the schedule from the last key down to the first.
	assign round_nx  = cmd.load_block ? '0 : round + 1'b1;
	assign dir_nx    = cmd.load_block ? kind : kind_q;
	assign rk_addr   = dir_nx ? (LAST_ROUND - round_nx) : round_nx;
	assign round_key = cmd.expand ? WORD_W'(round) : rk_rd_q;
	assign fwd_res   = fwd_round(x_q, y_q, round_key);
	assign inv_res   = inv_round(x_q, y_q, round_key);
	assign next_pair = (cmd.expand || !kind_q) ? fwd_res : inv_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q  <= '0;
			key_high_q <= '0;
		end else if (cfg_fire) begin
			if (cfg_index == REG_KEY_LOW) begin
				key_low_q <= cfg_data;
			end
			if (cfg_index == REG_KEY_HIGH) begin
				key_high_q <= cfg_data;
			end
		end
	end

	// During expansion x holds the B word and y the A word.
	always_ff @(posedge clk) begin
		if (cmd.load_block) begin
			x_q    <= data_in_high;
			y_q    <= data_in_low;
			kind_q <= kind;
		end else if (cmd.load_expand) begin
			x_q <= key_high_q;
			y_q <= key_low_q;
		end else if (cmd.step) begin
			x_q <= next_pair.x;
			y_q <= next_pair.y;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_rk) begin
			rk_mem[round] <= y_q;
		end
		rk_rd_q <= rk_mem[rk_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_low_q  <= y_q;
			out_high_q <= x_q;
		end
	end

	assign data_out_low  = out_low_q;
	assign data_out_high = out_high_q;

endmodule

// File: rtl/spk_ctrl.sv
`timescale 1ns / 1ps
module spk_ctrl #(
	parameter int ROUND_COUNT = spk_pkg::ROUND_COUNT_DEF,
	parameter int RND_W       = $clog2(ROUND_COUNT)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  spk_pkg::dp_status_t status,
	output spk_pkg::dp_cmd_t    cmd,
	output logic [RND_W-1:0]    round
);
	import spk_pkg::*;

	`include "speck128_128_block_cipher_unit_assert.svh"

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_EXPAND = 4'b0010,
		ST_RUN    = 4'b0100,
		ST_FIN    = 4'b1000
	} state_t;

	localparam logic [RND_W-1:0] LAST_ROUND = RND_W'(ROUND_COUNT - 1);

	state_t           state_q, state_d;
	logic [RND_W-1:0] round_q, round_d;
	logic             keys_ready_q, keys_ready_d;
	logic             out_valid_q, out_valid_d;
	logic             out_free, in_fire, last_round;

	assign out_free   = !out_valid_q || out_ready;
	assign last_round = (round_q == LAST_ROUND);
	// A new block may enter while the previous result moves to the output register.
	assign in_ready   = keys_ready_q && !status.key_write &&
		(state_q == ST_IDLE || (state_q == ST_FIN && out_free));
	assign in_fire    = in_valid && in_ready;

	always_comb begin
		state_d      = state_q;
		round_d      = round_q;
		keys_ready_d = keys_ready_q;
		out_valid_d  = out_valid_q && !out_ready;
		cmd          = '0;
		case (state_q)
			ST_IDLE: begin
				if (status.key_write) begin
					state_d = ST_IDLE;
				end else if (!keys_ready_q) begin
					cmd.load_expand = 1'b1;
					round_d         = '0;
					state_d         = ST_EXPAND;
				end else if (in_fire) begin
					cmd.load_block = 1'b1;
					round_d        = '0;
					state_d        = ST_RUN;
				end
			end
			ST_EXPAND: begin
				if (status.key_write) begin
					state_d = ST_IDLE;
				end else begin
					cmd.wr_rk  = 1'b1;
					cmd.step   = 1'b1;
					cmd.expand = 1'b1;
					if (last_round) begin
						keys_ready_d = 1'b1;
						round_d      = '0;
						state_d      = ST_IDLE;
					end else begin
						round_d = round_q + 1'b1;
					end
				end
			end
			ST_RUN: begin
				cmd.step = 1'b1;
				if (last_round) begin
					round_d = '0;
					state_d = ST_FIN;
				end else begin
					round_d = round_q + 1'b1;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					out_valid_d  = 1'b1;
					if (in_fire) begin
						cmd.load_block = 1'b1;
						round_d        = '0;
						state_d        = ST_RUN;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		if (status.key_write) begin
			keys_ready_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			round_q      <= '0;
			keys_ready_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			round_q      <= round_d;
			keys_ready_q <= keys_ready_d;
			out_valid_q  <= out_valid_d;
		end
	end

	assign out_valid = out_valid_q;
	assign round     = round_q;

	`SPK_ASSERT_SAME(a_fire_needs_keys, clk, arst_n, in_fire, keys_ready_q)
	`SPK_ASSERT_NEXT(a_run_ends_in_fin, clk, arst_n, state_q == ST_RUN && last_round,
		state_q == ST_FIN)
	`SPK_ASSERT_NEXT(a_load_sets_valid, clk, arst_n, cmd.load_out, out_valid_q)
	`SPK_ASSERT_NEXT(a_key_write_clears, clk, arst_n, status.key_write, !keys_ready_q)

endmodule

// File: rtl/speck128_128_block_cipher_unit.sv
// An accepted block is loaded into the round registers and runs through all rounds, one round
// a cycle, on the single round datapath; it then moves to the result register and is offered.
// A new block waits until the previous one has finished its rounds. After reset or a key write
// the key schedule is rebuilt (key words loaded, then expansion rounds) before a block is taken.
// Reset (arst_n, asynchronous, active low) clears the key registers and control state.
`timescale 1ns / 1ps
module speck128_128_block_cipher_unit #(
	parameter int ROUND_COUNT = spk_pkg::ROUND_COUNT_DEF
) (
	input logic        clk,
	input logic        arst_n,
	spk_in_if.sink     blk_in,
	spk_out_if.source  blk_out,
	spk_cfg_if.sink    cfg
);
	import spk_pkg::*;

	localparam int RND_W = $clog2(ROUND_COUNT);

	dp_cmd_t          cmd;
	dp_status_t       status;
	logic [RND_W-1:0] round;

	assign cfg.ready = 1'b1;

	spk_ctrl #(
		.ROUND_COUNT (ROUND_COUNT),
		.RND_W       (RND_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (blk_in.valid),
		.in_ready  (blk_in.ready),
		.out_valid (blk_out.valid),
		.out_ready (blk_out.ready),
		.status    (status),
		.cmd       (cmd),
		.round     (round)
	);

	spk_datapath #(
		.ROUND_COUNT (ROUND_COUNT),
		.RND_W       (RND_W)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.round         (round),
		.status        (status),
		.cfg_fire      (cfg.valid && cfg.ready),
		.cfg_index     (cfg.index),
		.cfg_data      (cfg.data),
		.kind          (blk_in.kind),
		.data_in_low   (blk_in.data_in_low),
		.data_in_high  (blk_in.data_in_high),
		.data_out_low  (blk_out.data_out_low),
		.data_out_high (blk_out.data_out_high)
	);

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
	import spk_pkg::*;

	localparam int ROUNDS = ROUND_COUNT_DEF;
	localparam logic DIR_ENC = 1'b0;
	localparam logic DIR_DEC = 1'b1;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_TOP = '1;
	localparam word_t ONES = '1;
	localparam int PHASES = 8;
	localparam int PHASE_BLOCKS = 212;
	localparam int HOLD_AFTER = 300;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 40;

	typedef struct packed {
		word_t lo;
		word_t hi;
	} block_t;

	typedef enum logic [1:0] {ROW_BLOCK, ROW_KNOWN, ROW_REG} row_kind_t;

	typedef struct packed {
		row_kind_t op;
		logic [CFG_IDX_W-1:0] idx;
		logic dir;
		word_t hi;
		word_t lo;
		word_t want_hi;
		word_t want_lo;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	spk_in_if blk_in ();
	spk_out_if blk_out ();
	spk_cfg_if cfg ();

	speck128_128_block_cipher_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.blk_in(blk_in),
		.blk_out(blk_out),
		.cfg(cfg)
	);

	always #5 clk = ~clk;

	// Mirror of the key registers and the expanded schedule.
	word_t key_lo = '0;
	word_t key_hi = '0;
	word_t sched [ROUNDS];
	bit sched_ok = 1'b0;

	block_t pending_blocks_q [$];
	stim_row_t directed [$];

	int n_sent = 0;
	int n_dec = 0;
	int n_results = 0;
	int n_errors = 0;
	int n_schedules = 0;
	int n_reg_writes = 0;
	bit no_gaps = 1'b0;
	bit sink_hold = 1'b0;
	int sink_wait = 0;
	int sink_seen = 0;

	function automatic void enc_round(inout word_t x, inout word_t y, input word_t k);
		x = ({x[7:0], x[63:8]} + y) ^ k;
		y = {y[60:0], y[63:61]} ^ x;
	endfunction

	function automatic void dec_round(inout word_t x, inout word_t y, input word_t k);
		y = y ^ x;
		y = {y[2:0], y[63:3]};
		x = (x ^ k) - y;
		x = {x[55:0], x[63:56]};
	endfunction

	task automatic build_schedule();
		word_t a;
		word_t b;
		a = key_lo;
		b = key_hi;
		for (int r = 0; r < ROUNDS - 1; r++) begin
			sched[r] = a;
			enc_round(b, a, word_t'(r));
		end
		sched[ROUNDS-1] = a;
		sched_ok = 1'b1;
		n_schedules++;
	endtask

	task automatic speck_block(input logic dir, input word_t lo, input word_t hi,
			output block_t res);
		word_t x;
		word_t y;
		x = hi;
		y = lo;
		if (!sched_ok)
			build_schedule();
		if (dir == DIR_ENC) begin
			for (int r = 0; r < ROUNDS; r++)
				enc_round(x, y, sched[r]);
		end else begin
			for (int r = ROUNDS - 1; r >= 0; r--)
				dec_round(x, y, sched[r]);
		end
		res.lo = y;
		res.hi = x;
	endtask

	function automatic int draw_gap();
		return no_gaps ? 0 : $urandom_range(0, 3);
	endfunction

	function automatic word_t rand_word();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return ONES;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic stim_row_t row_block(input logic dir, input word_t hi, input word_t lo);
		stim_row_t r;
		r = '0;
		r.op = ROW_BLOCK;
		r.dir = dir;
		r.hi = hi;
		r.lo = lo;
		return r;
	endfunction

	function automatic stim_row_t row_known(input logic dir, input word_t hi, input word_t lo,
			input word_t want_hi, input word_t want_lo);
		stim_row_t r;
		r = row_block(dir, hi, lo);
		r.op = ROW_KNOWN;
		r.want_hi = want_hi;
		r.want_lo = want_lo;
		return r;
	endfunction

	function automatic stim_row_t row_reg(input logic [CFG_IDX_W-1:0] idx, input word_t data);
		stim_row_t r;
		r = '0;
		r.op = ROW_REG;
		r.idx = idx;
		r.lo = data;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input word_t got, input word_t want);
		$display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $time);
		n_errors++;
	endtask

	// One block transfer; the expectation is recorded at the accepting edge.
	task automatic send_block(input logic dir, input word_t lo, input word_t hi,
			input bit typed, input block_t typed_res);
		int gap;
		block_t res;
		gap = draw_gap();
		@(negedge clk);
		if (gap != 0) begin
			blk_in.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		blk_in.valid <= 1'b1;
		blk_in.kind <= dir;
		blk_in.data_in_low <= lo;
		blk_in.data_in_high <= hi;
		do @(posedge clk); while (!blk_in.ready);
		speck_block(dir, lo, hi, res);
		pending_blocks_q.push_back(typed ? typed_res : res);
		n_sent++;
		if (dir == DIR_DEC)
			n_dec++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input word_t data);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= data;
		do @(posedge clk); while (!cfg.ready);
		if (idx == REG_KEY_LOW) begin
			key_lo = data;
			sched_ok = 1'b0;
		end else if (idx == REG_KEY_HIGH) begin
			key_hi = data;
			sched_ok = 1'b0;
		end
		n_reg_writes++;
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	// Stops offering blocks and waits for every outstanding result.
	task automatic settle();
		@(negedge clk);
		blk_in.valid <= 1'b0;
		while (pending_blocks_q.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		block_t want;
		if (arst_n && blk_out.valid && blk_out.ready) begin
			n_results++;
			if (pending_blocks_q.size() == 0) begin
				report_mismatch("result with nothing outstanding", blk_out.data_out_low, '0);
			end else begin
				want = pending_blocks_q.pop_front();
				if (blk_out.data_out_low !== want.lo)
					report_mismatch("data_out_low", blk_out.data_out_low, want.lo);
				if (blk_out.data_out_high !== want.hi)
					report_mismatch("data_out_high", blk_out.data_out_high, want.hi);
			end
		end
	end

	// Result side: a fresh stall is drawn after each transfer.
	always @(negedge clk) begin
		if (sink_seen != n_results) begin
			sink_seen = n_results;
			sink_wait = draw_gap();
		end
		if (sink_wait != 0) begin
			sink_wait--;
			blk_out.ready <= 1'b0;
		end else begin
			blk_out.ready <= !sink_hold;
		end
	end

	// A long hold on the result side while blocks keep being offered.
	initial begin
		wait (n_sent >= HOLD_AFTER);
		@(posedge clk);
		sink_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		sink_hold <= 1'b0;
	end

	initial begin
		#8000000;
		$display("speck128_128_block_cipher_unit regression: fail");
		$finish;
	end

	initial begin
		logic dir;
		int sel;
		blk_in.valid = 1'b0;
		blk_in.kind = DIR_ENC;
		blk_in.data_in_low = '0;
		blk_in.data_in_high = '0;
		blk_out.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = REG_KEY_LOW;
		cfg.data = '0;

		// The published Speck128/128 vector sits in the middle of the table.
		directed.push_back(row_block(DIR_ENC, '0, '0));
		directed.push_back(row_block(DIR_DEC, ONES, ONES));
		directed.push_back(row_reg(REG_KEY_LOW, 64'h0706050403020100));
		directed.push_back(row_reg(REG_KEY_HIGH, 64'h0f0e0d0c0b0a0908));
		directed.push_back(row_known(DIR_ENC, 64'h6c61766975716520, 64'h7469206564616d20,
			64'ha65d985179783265, 64'h7860fedf5c570d18));
		directed.push_back(row_known(DIR_DEC, 64'ha65d985179783265, 64'h7860fedf5c570d18,
			64'h6c61766975716520, 64'h7469206564616d20));
		directed.push_back(row_block(DIR_ENC, '0, '0));
		directed.push_back(row_block(DIR_ENC, ONES, ONES));
		directed.push_back(row_block(DIR_DEC, '0, '0));
		directed.push_back(row_block(DIR_DEC, ONES, ONES));
		directed.push_back(row_block(DIR_ENC, '0, ONES));
		directed.push_back(row_block(DIR_DEC, ONES, '0));
		// A write to an unused index must leave the key alone.
		directed.push_back(row_reg(REG_FIRST_UNUSED, ONES));
		directed.push_back(row_known(DIR_ENC, 64'h6c61766975716520, 64'h7469206564616d20,
			64'ha65d985179783265, 64'h7860fedf5c570d18));
		directed.push_back(row_reg(REG_KEY_LOW, ONES));
		directed.push_back(row_reg(REG_KEY_HIGH, ONES));
		directed.push_back(row_block(DIR_ENC, '0, '0));
		directed.push_back(row_block(DIR_DEC, ONES, ONES));
		directed.push_back(row_reg(REG_KEY_HIGH, '0));
		directed.push_back(row_block(DIR_ENC, ONES, '0));
		directed.push_back(row_reg(REG_TOP, 64'h5a5a5a5a5a5a5a5a));
		directed.push_back(row_block(DIR_DEC, '0, ONES));
		directed.push_back(row_reg(REG_KEY_LOW, '0));
		directed.push_back(row_block(DIR_ENC, '0, '0));

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed[i]) begin
			case (directed[i].op)
				ROW_REG: begin
					settle();
					write_reg(directed[i].idx, directed[i].lo);
				end
				ROW_KNOWN: send_block(directed[i].dir, directed[i].lo, directed[i].hi, 1'b1,
					{directed[i].want_lo, directed[i].want_hi});
				default: send_block(directed[i].dir, directed[i].lo, directed[i].hi, 1'b0, '0);
			endcase
		end

		for (int p = 0; p < PHASES; p++) begin
			settle();
			no_gaps = (p % 3 == 1);
			case (p)
				0: begin
					write_reg(REG_KEY_LOW, '0);
					write_reg(REG_KEY_HIGH, '0);
				end
				1: begin
					write_reg(REG_KEY_LOW, ONES);
					write_reg(REG_KEY_HIGH, ONES);
				end
				2: begin
					write_reg(REG_KEY_LOW, ONES);
					write_reg(REG_KEY_HIGH, '0);
				end
				default: begin
					sel = $urandom_range(1, 3);
					if (sel[0])
						write_reg(REG_KEY_LOW, {$urandom, $urandom});
					if (sel[1])
						write_reg(REG_KEY_HIGH, {$urandom, $urandom});
				end
			endcase
			if ($urandom_range(0, 1) != 0)
				write_reg(CFG_IDX_W'($urandom_range(2, 255)), rand_word());
			repeat (PHASE_BLOCKS) begin
				dir = 1'($urandom_range(0, 1));
				send_block(dir, rand_word(), rand_word(), 1'b0, '0);
			end
		end

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Covered %0d blocks (%0d decryptions) under %0d key schedules, %0d register writes.",
			n_sent, n_dec, n_schedules, n_reg_writes);
		$display("Checked %0d results with %0d mismatches.", n_results, n_errors);
		if (n_errors == 0)
			$display("speck128_128_block_cipher_unit regression: pass");
		else
			$display("speck128_128_block_cipher_unit regression: fail");
		$finish;
	end

endmodule

// File: sim.f
+incdir+rtl
rtl/spk_pkg.sv
rtl/spk_in_if.sv
rtl/spk_out_if.sv
rtl/spk_cfg_if.sv
rtl/spk_datapath.sv
rtl/spk_ctrl.sv
rtl/speck128_128_block_cipher_unit.sv
dv/tb_top.sv
